@@ rtl/core/hcb_pkg.sv @@
// Shared types, constants and command codes for the Huffman code builder.
package hcb_pkg;

  localparam int HCB_MAX_SYMBOLS  = 64;
  localparam int HCB_MAX_CODE_LEN = 16;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [31:0] weight;
    logic        last;
  } hcb_in_t;

  typedef struct packed {
    logic [7:0]  leaf_symbol;
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic        too_long;
    logic        end_of_table;
  } hcb_out_t;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
  localparam logic [OP_W-1:0] OP_HINIT  = 5'd2;
  localparam logic [OP_W-1:0] OP_HLOADX = 5'd3;
  localparam logic [OP_W-1:0] OP_LATCHX = 5'd4;
  localparam logic [OP_W-1:0] OP_SDA    = 5'd5;
  localparam logic [OP_W-1:0] OP_SDB    = 5'd6;
  localparam logic [OP_W-1:0] OP_SDC    = 5'd7;
  localparam logic [OP_W-1:0] OP_HNEXT  = 5'd8;
  localparam logic [OP_W-1:0] OP_POPA   = 5'd9;
  localparam logic [OP_W-1:0] OP_POPB   = 5'd10;
  localparam logic [OP_W-1:0] OP_MGA    = 5'd11;
  localparam logic [OP_W-1:0] OP_MGB    = 5'd12;
  localparam logic [OP_W-1:0] OP_SUA    = 5'd13;
  localparam logic [OP_W-1:0] OP_SUB    = 5'd14;
  localparam logic [OP_W-1:0] OP_SUC    = 5'd15;
  localparam logic [OP_W-1:0] OP_SUFIN  = 5'd16;
  localparam logic [OP_W-1:0] OP_RTA    = 5'd17;
  localparam logic [OP_W-1:0] OP_RTB    = 5'd18;
  localparam logic [OP_W-1:0] OP_WCHK   = 5'd19;
  localparam logic [OP_W-1:0] OP_WDESC  = 5'd20;
  localparam logic [OP_W-1:0] OP_WEMIT  = 5'd21;
  localparam logic [OP_W-1:0] OP_WPOP   = 5'd22;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            second;
  } hcb_cmd_t;

  typedef struct packed {
    logic cnt_ge2;
    logic hv_zero;
    logic size_gt1;
    logic hi_zero;
    logic sd_done;
    logic su_less;
    logic leaf;
    logic sp_zero;
  } hcb_stat_t;

endpackage

@@ rtl/core/hcb_ctrl.sv @@
// Sequencer that steps the datapath through load, heap build, merging and tree walk.
module hcb_ctrl
  import hcb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_last,
  input  hcb_stat_t stat,
  output logic      busy,
  output hcb_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_HINIT  = 5'd1;
  localparam logic [4:0] S_HLOADX = 5'd2;
  localparam logic [4:0] S_HLOADW = 5'd3;
  localparam logic [4:0] S_SDA    = 5'd4;
  localparam logic [4:0] S_SDB    = 5'd5;
  localparam logic [4:0] S_SDC    = 5'd6;
  localparam logic [4:0] S_HNEXT  = 5'd7;
  localparam logic [4:0] S_MCHK   = 5'd8;
  localparam logic [4:0] S_PA     = 5'd9;
  localparam logic [4:0] S_PB     = 5'd10;
  localparam logic [4:0] S_PC     = 5'd11;
  localparam logic [4:0] S_MGA    = 5'd12;
  localparam logic [4:0] S_MGB    = 5'd13;
  localparam logic [4:0] S_SUCHK  = 5'd14;
  localparam logic [4:0] S_SUB    = 5'd15;
  localparam logic [4:0] S_SUC    = 5'd16;
  localparam logic [4:0] S_RTA    = 5'd17;
  localparam logic [4:0] S_RTB    = 5'd18;
  localparam logic [4:0] S_WCHK   = 5'd19;
  localparam logic [4:0] S_WDESC  = 5'd20;
  localparam logic [4:0] S_WEMIT  = 5'd21;
  localparam logic [4:0] S_WPOP   = 5'd22;

  localparam logic [1:0] CTX_HEAP = 2'd0;
  localparam logic [1:0] CTX_POP1 = 2'd1;
  localparam logic [1:0] CTX_POP2 = 2'd2;

  logic [4:0] state_r, state_nxt;
  logic [1:0] ctx_r, ctx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctx_r   <= CTX_HEAP;
    end else begin
      state_r <= state_nxt;
      ctx_r   <= ctx_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    ctx_nxt    = ctx_r;
    cmd.op     = OP_NOP;
    cmd.second = (ctx_r == CTX_POP2);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (in_last) state_nxt = S_HINIT;
        end
      end
      S_HINIT: begin
        cmd.op    = OP_HINIT;
        state_nxt = stat.cnt_ge2 ? S_HLOADX : S_RTA;
      end
      S_HLOADX: begin
        cmd.op    = OP_HLOADX;
        ctx_nxt   = CTX_HEAP;
        state_nxt = S_HLOADW;
      end
      S_HLOADW: begin
        cmd.op    = OP_LATCHX;
        state_nxt = S_SDA;
      end
      S_SDA: begin
        cmd.op    = OP_SDA;
        state_nxt = S_SDB;
      end
      S_SDB: begin
        cmd.op    = OP_SDB;
        state_nxt = S_SDC;
      end
      S_SDC: begin
        cmd.op = OP_SDC;
        if (!stat.sd_done) begin
          state_nxt = S_SDA;
        end else begin
          case (ctx_r)
            CTX_HEAP: state_nxt = S_HNEXT;
            CTX_POP1: begin
              ctx_nxt   = CTX_POP2;
              state_nxt = S_PA;
            end
            default:  state_nxt = S_MGA;
          endcase
        end
      end
      S_HNEXT: begin
        if (stat.hv_zero) begin
          state_nxt = S_MCHK;
        end else begin
          cmd.op    = OP_HNEXT;
          state_nxt = S_HLOADX;
        end
      end
      S_MCHK: begin
        if (stat.size_gt1) begin
          ctx_nxt   = CTX_POP1;
          state_nxt = S_PA;
        end else begin
          state_nxt = S_RTA;
        end
      end
      S_PA: begin
        cmd.op    = OP_POPA;
        state_nxt = S_PB;
      end
      S_PB: begin
        cmd.op    = OP_POPB;
        state_nxt = S_PC;
      end
      S_PC: begin
        cmd.op    = OP_LATCHX;
        state_nxt = S_SDA;
      end
      S_MGA: begin
        cmd.op    = OP_MGA;
        state_nxt = S_MGB;
      end
      S_MGB: begin
        cmd.op    = OP_MGB;
        state_nxt = S_SUCHK;
      end
      S_SUCHK: begin
        if (stat.hi_zero) begin
          cmd.op    = OP_SUFIN;
          state_nxt = S_MCHK;
        end else begin
          cmd.op    = OP_SUA;
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        cmd.op    = OP_SUB;
        state_nxt = S_SUC;
      end
      S_SUC: begin
        cmd.op    = OP_SUC;
        state_nxt = stat.su_less ? S_SUCHK : S_MCHK;
      end
      S_RTA: begin
        cmd.op    = OP_RTA;
        state_nxt = S_RTB;
      end
      S_RTB: begin
        cmd.op    = OP_RTB;
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        cmd.op    = OP_WCHK;
        state_nxt = stat.leaf ? S_WEMIT : S_WDESC;
      end
      S_WDESC: begin
        cmd.op    = OP_WDESC;
        state_nxt = S_WCHK;
      end
      S_WEMIT: begin
        cmd.op    = OP_WEMIT;
        state_nxt = stat.sp_zero ? S_IDLE : S_WPOP;
      end
      S_WPOP: begin
        cmd.op    = OP_WPOP;
        state_nxt = S_WCHK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/hcb_dp.sv @@
// Datapath: symbol and node stores, heap array, walk stack and result register.
module hcb_dp
  import hcb_pkg::*;
#(
  parameter int MAX_SYMBOLS  = HCB_MAX_SYMBOLS,
  parameter int MAX_CODE_LEN = HCB_MAX_CODE_LEN
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  hcb_cmd_t  cmd,
  input  hcb_in_t   in_data,
  output hcb_stat_t stat,
  output logic      out_strobe,
  output hcb_out_t  out_data
);

  localparam int NODE_CAP = 2 * MAX_SYMBOLS - 1;
  localparam int NW = $clog2(NODE_CAP);
  localparam int HW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int PW = HW + 2;
  localparam int WW = 32 + $clog2(MAX_SYMBOLS);
  localparam int CL = MAX_CODE_LEN;
  localparam int DW = $clog2(((MAX_SYMBOLS > MAX_CODE_LEN) ? MAX_SYMBOLS : MAX_CODE_LEN) + 1);
  localparam int EW = NW + CL + DW;

  // Stores
  logic [7:0]    sym_mem [MAX_SYMBOLS];
  logic [WW-1:0] wt_mem  [NODE_CAP];
  logic [NW-1:0] lc_mem  [NODE_CAP];
  logic [NW-1:0] rc_mem  [NODE_CAP];
  logic [NW-1:0] hp_mem  [MAX_SYMBOLS];
  logic [EW-1:0] stk_mem [MAX_SYMBOLS];

  logic [7:0]    sym_q;
  logic [WW-1:0] wt_q0, wt_q1;
  logic [NW-1:0] lc_q, rc_q;
  logic [NW-1:0] hp_q0, hp_q1;
  logic [EW-1:0] stk_q;

  // Port controls
  logic          sym_we, sym_re;
  logic [HW-1:0] sym_wa, sym_ra;
  logic          wt_we, wt_re;
  logic [NW-1:0] wt_wa, wt_ra0, wt_ra1;
  logic [WW-1:0] wt_wd;
  logic          ch_we, ch_re;
  logic [NW-1:0] ch_wa, ch_ra;
  logic          hp_we, hp_re;
  logic [HW-1:0] hp_wa, hp_ra0, hp_ra1;
  logic [NW-1:0] hp_wd;
  logic          stk_we, stk_re;
  logic [HW-1:0] stk_wa, stk_ra;
  logic [EW-1:0] stk_wd;

  // Working registers
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [NW-1:0] next_r, next_nxt;
  logic [HW-1:0] hv_r, hv_nxt;
  logic [HW-1:0] hi_r, hi_nxt;
  logic [NW-1:0] xn_r, xn_nxt;
  logic [WW-1:0] xw_r, xw_nxt;
  logic [NW-1:0] a_r, a_nxt;
  logic [NW-1:0] b_r, b_nxt;
  logic [NW-1:0] nd_r, nd_nxt;
  logic [CL-1:0] code_r, code_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic          strobe_r, strobe_nxt;
  hcb_out_t      out_r, out_nxt;

  // Helpers
  logic [PW-1:0] lpos, rpos, pick_pos;
  logic          lv, rv;
  logic [WW-1:0] wsmall;
  logic [NW-1:0] nsmall;
  logic [HW-1:0] par;
  logic [CL-1:0] code_l, code_r1;
  logic [WW-1:0] sum;
  logic          over;
  logic [DW-1:0] len;

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_wa] <= in_data.symbol;
    if (sym_re) sym_q <= sym_mem[sym_ra];
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    if (wt_re) begin
      wt_q0 <= wt_mem[wt_ra0];
      wt_q1 <= wt_mem[wt_ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      lc_mem[ch_wa] <= a_r;
      rc_mem[ch_wa] <= b_r;
    end
    if (ch_re) begin
      lc_q <= lc_mem[ch_ra];
      rc_q <= rc_mem[ch_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (hp_we) hp_mem[hp_wa] <= hp_wd;
    if (hp_re) begin
      hp_q0 <= hp_mem[hp_ra0];
      hp_q1 <= hp_mem[hp_ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_q <= stk_mem[stk_ra];
  end

  // Sift-down choice: the moving node sits in a hole at hi; left child wins ties first.
  always_comb begin
    lpos     = PW'({hi_r, 1'b1});
    rpos     = lpos + PW'(1);
    lv       = lpos < PW'(size_r);
    rv       = rpos < PW'(size_r);
    pick_pos = PW'(hi_r);
    wsmall   = xw_r;
    nsmall   = xn_r;
    if (lv && (wt_q0 < wsmall)) begin
      pick_pos = lpos;
      wsmall   = wt_q0;
      nsmall   = hp_q0;
    end
    if (rv && (wt_q1 < wsmall)) begin
      pick_pos = rpos;
      nsmall   = hp_q1;
    end
  end

  assign par     = HW'((hi_r - HW'(1)) >> 1);
  assign code_l  = (depth_r < DW'(CL)) ? CL'({code_r, 1'b0}) : code_r;
  assign code_r1 = (depth_r < DW'(CL)) ? CL'({code_r, 1'b1}) : code_r;
  assign sum     = wt_q0 + wt_q1;
  assign over    = depth_r > DW'(CL);
  assign len     = over ? DW'(CL) : depth_r;

  assign stat.cnt_ge2  = cnt_r >= CW'(2);
  assign stat.hv_zero  = (hv_r == '0);
  assign stat.size_gt1 = size_r > CW'(1);
  assign stat.hi_zero  = (hi_r == '0);
  assign stat.sd_done  = (pick_pos == PW'(hi_r));
  assign stat.su_less  = xw_r < wt_q0;
  assign stat.leaf     = nd_r < NW'(cnt_r);
  assign stat.sp_zero  = (sp_r == '0);

  always_comb begin
    sym_we = 1'b0; sym_re = 1'b0; sym_wa = HW'(cnt_r); sym_ra = nd_r[HW-1:0];
    wt_we = 1'b0; wt_re = 1'b0; wt_wa = NW'(cnt_r); wt_wd = WW'(in_data.weight);
    wt_ra0 = hp_q0; wt_ra1 = hp_q1;
    ch_we = 1'b0; ch_re = 1'b0; ch_wa = next_r; ch_ra = nd_r;
    hp_we = 1'b0; hp_re = 1'b0; hp_wa = hi_r; hp_wd = xn_r;
    hp_ra0 = lpos[HW-1:0]; hp_ra1 = rpos[HW-1:0];
    stk_we = 1'b0; stk_re = 1'b0; stk_wa = sp_r[HW-1:0];
    stk_ra = HW'(sp_r - CW'(1));
    stk_wd = {rc_q, code_r1, DW'(depth_r + DW'(1))};
    cnt_nxt = cnt_r; size_nxt = size_r; next_nxt = next_r; hv_nxt = hv_r;
    hi_nxt = hi_r; xn_nxt = xn_r; xw_nxt = xw_r; a_nxt = a_r; b_nxt = b_r;
    nd_nxt = nd_r; code_nxt = code_r; depth_nxt = depth_r; sp_nxt = sp_r;
    strobe_nxt = 1'b0; out_nxt = out_r;
    case (cmd.op)
      OP_LOAD: begin
        if (cnt_r < CW'(MAX_SYMBOLS)) begin
          sym_we  = 1'b1;
          wt_we   = 1'b1;
          hp_we   = 1'b1;
          hp_wa   = HW'(cnt_r);
          hp_wd   = NW'(cnt_r);
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      OP_HINIT: begin
        size_nxt = cnt_r;
        next_nxt = NW'(cnt_r);
        hv_nxt   = HW'((cnt_r - CW'(2)) >> 1);
      end
      OP_HLOADX: begin
        wt_re  = 1'b1;
        wt_ra0 = NW'(hv_r);
        hi_nxt = hv_r;
        xn_nxt = NW'(hv_r);
      end
      OP_LATCHX: xw_nxt = wt_q0;
      OP_SDA:    hp_re = 1'b1;
      OP_SDB:    wt_re = 1'b1;
      OP_SDC: begin
        hp_we = 1'b1;
        if (pick_pos != PW'(hi_r)) begin
          hp_wd  = nsmall;
          hi_nxt = pick_pos[HW-1:0];
        end
      end
      OP_HNEXT: hv_nxt = hv_r - HW'(1);
      OP_POPA: begin
        hp_re  = 1'b1;
        hp_ra0 = '0;
        hp_ra1 = HW'(size_r - CW'(1));
      end
      OP_POPB: begin
        if (cmd.second) b_nxt = hp_q0;
        else            a_nxt = hp_q0;
        xn_nxt   = hp_q1;
        wt_re    = 1'b1;
        wt_ra0   = hp_q1;
        size_nxt = size_r - CW'(1);
        hi_nxt   = '0;
      end
      OP_MGA: begin
        wt_re  = 1'b1;
        wt_ra0 = a_r;
        wt_ra1 = b_r;
      end
      OP_MGB: begin
        wt_we    = 1'b1;
        wt_wa    = next_r;
        wt_wd    = sum;
        ch_we    = 1'b1;
        xn_nxt   = next_r;
        xw_nxt   = sum;
        hi_nxt   = HW'(size_r);
        size_nxt = size_r + CW'(1);
        next_nxt = next_r + NW'(1);
      end
      OP_SUA: begin
        hp_re  = 1'b1;
        hp_ra0 = par;
      end
      OP_SUB: begin
        wt_re  = 1'b1;
        wt_ra0 = hp_q0;
      end
      OP_SUC: begin
        hp_we = 1'b1;
        if (xw_r < wt_q0) begin
          hp_wd  = hp_q0;
          hi_nxt = par;
        end
      end
      OP_SUFIN: hp_we = 1'b1;
      OP_RTA: begin
        hp_re  = 1'b1;
        hp_ra0 = '0;
      end
      OP_RTB: begin
        nd_nxt    = hp_q0;
        code_nxt  = '0;
        depth_nxt = '0;
        sp_nxt    = '0;
      end
      OP_WCHK: begin
        if (nd_r < NW'(cnt_r)) sym_re = 1'b1;
        else                   ch_re  = 1'b1;
      end
      OP_WDESC: begin
        // Right branch waits on the stack; the walk carries on down the left.
        stk_we    = 1'b1;
        sp_nxt    = sp_r + CW'(1);
        nd_nxt    = lc_q;
        code_nxt  = code_l;
        depth_nxt = depth_r + DW'(1);
      end
      OP_WEMIT: begin
        strobe_nxt           = 1'b1;
        out_nxt.leaf_symbol  = sym_q;
        out_nxt.code_bits    = 16'(code_r);
        out_nxt.code_length  = 5'(len);
        out_nxt.too_long     = over;
        out_nxt.end_of_table = (sp_r == '0);
        if (sp_r == '0) begin
          cnt_nxt  = '0;
          size_nxt = '0;
        end else begin
          stk_re = 1'b1;
          sp_nxt = sp_r - CW'(1);
        end
      end
      OP_WPOP: begin
        nd_nxt    = stk_q[EW-1 -: NW];
        code_nxt  = stk_q[DW +: CL];
        depth_nxt = stk_q[DW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      size_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      size_r   <= size_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_r  <= next_nxt;
    hv_r    <= hv_nxt;
    hi_r    <= hi_nxt;
    xn_r    <= xn_nxt;
    xw_r    <= xw_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    nd_r    <= nd_nxt;
    code_r  <= code_nxt;
    depth_r <= depth_nxt;
    sp_r    <= sp_nxt;
    out_r   <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

@@ rtl/core/huffman_code_builder.sv @@
// Top level of the Huffman code builder: sequencer plus datapath.
//
// Input: a (symbol, weight, last) transaction is taken at each rising edge with start high
// and busy low. Loads run at one transaction per cycle; up to MAX_SYMBOLS pairs are kept and
// further pairs are dropped. The transaction with last set is stored too and starts the build,
// during which busy stays high and no transaction is taken.
// Build: heap construction and each pop sift a node down one heap level per pass of reading
// the children, reading their weights and moving the hole; each insertion climbs one level per
// pass of reading the parent, reading its weight and moving the hole. The walk checks each node,
// then descends from an internal node, or emits a leaf and, unless the stack is empty, pops a branch.
// Output: one result per leaf in preorder, shown for exactly one cycle with out_strobe high;
// the final one carries end_of_table, and busy falls in that same cycle. The receiver
// cannot hold results off, so results never wait.
// Reset (synchronous, rst_n low) clears the load count and the sequencer; the stores are
// not cleared and need no clearing pass.
module huffman_code_builder
  import hcb_pkg::*;
#(
  parameter int MAX_SYMBOLS  = HCB_MAX_SYMBOLS,
  parameter int MAX_CODE_LEN = HCB_MAX_CODE_LEN
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hcb_in_t  in_data,
  output logic     out_strobe,
  output hcb_out_t out_data
);

  hcb_cmd_t  cmd;
  hcb_stat_t stat;

  hcb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_data.last),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  hcb_dp #(
    .MAX_SYMBOLS  (MAX_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

@@ rtl/core/hcb_checker.sv @@
// Port-level checks for the Huffman code builder, bound to the top level.
module hcb_checker
  import hcb_pkg::*;
#(
  parameter int MAX_CODE_LEN = HCB_MAX_CODE_LEN
)
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input hcb_in_t  in_data,
  input logic     out_strobe,
  input hcb_out_t out_data
);

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last) |=> busy)
    else $error("last transaction did not start the build");

  a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.last) |=> !busy)
    else $error("plain load made the block busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.end_of_table) |-> busy)
    else $error("result before end of table while idle");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_strobe && out_data.end_of_table))
    else $error("build ended without an end-of-table result");

  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.too_long) |-> (out_data.code_length == 5'(MAX_CODE_LEN)))
    else $error("truncated code without saturated length");

endmodule

bind huffman_code_builder hcb_checker #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_hcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
